/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

/* rtl/u8s_pkg.sv */
// ----------------------------------------------------------------------------
// u8s_pkg
// Shared types and constants of the UTF-8 stream sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

  // Replacement character U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Byte class, decoded once at the front
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } u8s_cls_t;

  // Input word
  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } u8s_in_t;

  // Result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_replacement;
    logic       last_of_run;
  } u8s_out_t;

  // One buffered byte with its class
  typedef struct packed {
    logic [7:0] data;
    u8s_cls_t   cls;
  } u8s_ent_t;

  // Decoded request passed from front to back
  typedef struct packed {
    logic     flush;
    u8s_ent_t ent;
  } u8s_req_t;

endpackage

/* rtl/u8s_front.sv */
// ----------------------------------------------------------------------------
// u8s_front
// Accepts input words, classifies the byte and queues decoded requests.
// ----------------------------------------------------------------------------
module u8s_front import u8s_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  u8s_in_t  in_req,
  output logic     q_valid,
  output u8s_req_t q_req,
  input  logic     q_take
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;

  function automatic u8s_cls_t classify(input logic [7:0] b);
    u8s_cls_t c;
    if (b <= ASCII_MAX) begin
      c = CLS_ASCII;
    end else if (b <= CONT_MAX) begin
      c = CLS_CONT;
    end else if (b < LEAD2_MIN) begin
      c = CLS_BAD;
    end else if (b <= LEAD2_MAX) begin
      c = CLS_LEAD2;
    end else if (b <= LEAD3_MAX) begin
      c = CLS_LEAD3;
    end else if (b <= LEAD4_MAX) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_BAD;
    end
    return c;
  endfunction

  u8s_req_t          slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              push_ok;
  u8s_req_t          dec_req;

  // Decode the incoming word
  always_comb begin
    dec_req.flush    = in_req.req_type;
    dec_req.ent.data = in_req.in_byte;
    dec_req.ent.cls  = classify(in_req.in_byte);
  end

  assign full    = (cnt_r == CW'(DEPTH));
  assign push_ok = push && !full;
  assign q_valid = (cnt_r != '0);
  assign q_req   = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_take) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_ok, q_take})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the decoded word
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= dec_req;
    end
  end

endmodule

/* rtl/u8s_back.sv */
// ----------------------------------------------------------------------------
// u8s_back
// Scans held bytes and a request; emits clean bytes one a cycle unless stalled.
// ----------------------------------------------------------------------------
module u8s_back import u8s_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  u8s_req_t q_req,
  output logic     q_take,
  input  logic     pop,
  output logic     empty,
  output u8s_out_t out_res
);

  localparam logic [7:0] E0_LEAD = 8'hE0;
  localparam logic [7:0] E0_MIN  = 8'hA0;
  localparam logic [7:0] ED_LEAD = 8'hED;
  localparam logic [7:0] ED_MAX  = 8'h9F;
  localparam logic [7:0] F0_LEAD = 8'hF0;
  localparam logic [7:0] F0_MIN  = 8'h90;
  localparam logic [7:0] F4_LEAD = 8'hF4;
  localparam logic [7:0] F4_MAX  = 8'h8F;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;
  typedef enum logic [1:0] {ACT_STOP, ACT_PASS, ACT_REPL} act_t;

  typedef struct packed {
    act_t       act;
    logic [2:0] nout;
  } step_t;

  // Decide what to do with the byte at the head of the buffer
  function automatic step_t scan_lead(input u8s_ent_t [3:0] e, input logic [2:0] n,
                                      input logic flush);
    step_t      s;
    logic [2:0] need;
    logic       pre_ok;
    logic       seq_ok;
    logic [7:0] lead;
    logic [7:0] sec;
    logic       c1, c2, c3;
    lead = e[0].data;
    sec  = e[1].data;
    c1   = (e[1].cls == CLS_CONT);
    c2   = (e[2].cls == CLS_CONT);
    c3   = (e[3].cls == CLS_CONT);
    unique case (e[0].cls)
      CLS_ASCII: need = 3'd1;
      CLS_LEAD2: need = 3'd2;
      CLS_LEAD3: need = 3'd3;
      CLS_LEAD4: need = 3'd4;
      default:   need = 3'd0;
    endcase
    pre_ok = (n < 3'd2 || c1) && (n < 3'd3 || c2);
    seq_ok = (need < 3'd2 || c1) && (need < 3'd3 || c2) && (need < 3'd4 || c3) &&
             (need != 3'd3 || ((lead != E0_LEAD || sec >= E0_MIN) &&
                               (lead != ED_LEAD || sec <= ED_MAX))) &&
             (need != 3'd4 || ((lead != F0_LEAD || sec >= F0_MIN) &&
                               (lead != F4_LEAD || sec <= F4_MAX)));
    s.act  = ACT_REPL;
    s.nout = 3'd3;
    if (n == 3'd0) begin
      s.act  = ACT_STOP;
      s.nout = 3'd0;
    end else if (need == 3'd0) begin
      s.act  = ACT_REPL;
      s.nout = 3'd3;
    end else if (n < need) begin
      if (pre_ok && !flush) begin
        s.act  = ACT_STOP;
        s.nout = 3'd0;
      end
    end else if (seq_ok) begin
      s.act  = ACT_PASS;
      s.nout = need;
    end
    return s;
  endfunction

  state_t           state_r, state_nxt;
  u8s_ent_t [3:0]   ent_r, ent_nxt;
  logic [2:0]       n_r, n_nxt;
  logic             flush_r, flush_nxt;
  logic             busy_r, busy_nxt;
  logic             kind_r, kind_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  u8s_out_t         out_r, out_nxt;

  u8s_ent_t [3:0]   ent_sh;
  logic [2:0]       n_dec;
  step_t            step0;
  step_t            step1;
  act_t             act;
  logic [1:0]       rem;
  logic             slot_free;
  logic             run_end;

  assign empty   = !out_valid_r;
  assign out_res = out_r;

  // Buffer after dropping its head byte
  assign ent_sh = {ent_r[3], ent_r[3], ent_r[2], ent_r[1]};
  assign n_dec  = n_r - 3'd1;

  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    n_nxt         = n_r;
    flush_nxt     = flush_r;
    busy_nxt      = busy_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    q_take        = 1'b0;

    slot_free = !out_valid_r || pop;
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    step0 = scan_lead(ent_r, n_r, flush_r);
    step1 = scan_lead(ent_sh, n_dec, flush_r);
    if (busy_r) begin
      act = kind_r ? ACT_REPL : ACT_PASS;
      rem = cnt_r;
    end else begin
      act = step0.act;
      rem = 2'(step0.nout - 3'd1);
    end
    run_end = (rem == 2'd0) && (step1.act == ACT_STOP);

    unique case (state_r)
      ST_IDLE: begin
        // Append the new byte to the held prefix, or latch a flush request
        if (q_valid) begin
          q_take    = 1'b1;
          flush_nxt = q_req.flush;
          if (!q_req.flush) begin
            ent_nxt[n_r[1:0]] = q_req.ent;
            n_nxt             = n_r + 3'd1;
          end
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (act == ACT_STOP) begin
          // Nothing more to emit: the buffer now holds the prefix
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.is_replacement = (act == ACT_REPL);
          out_nxt.last_of_run    = run_end;
          if (act == ACT_REPL) begin
            case (rem)
              2'd2:    out_nxt.out_byte = REPL_B0;
              2'd1:    out_nxt.out_byte = REPL_B1;
              default: out_nxt.out_byte = REPL_B2;
            endcase
          end else begin
            out_nxt.out_byte = ent_r[0].data;
          end
          busy_nxt = (rem != 2'd0);
          kind_nxt = (act == ACT_REPL);
          cnt_nxt  = rem - 2'd1;
          // Drop the head byte: every passed byte, or a replaced byte after its last U+FFFD byte
          if (act == ACT_PASS || rem == 2'd0) begin
            ent_nxt = ent_sh;
            n_nxt   = n_dec;
          end
          if (run_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= 3'd0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ent_r   <= ent_nxt;
    flush_r <= flush_nxt;
    kind_r  <= kind_nxt;
    cnt_r   <= cnt_nxt;
    out_r   <= out_nxt;
  end

endmodule

/* rtl/utf8_stream_sanitizer.sv */
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// UTF-8 byte stream cleaner that swaps malformed input for U+FFFD.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: a word (req_type, in_byte) is taken when push is high and
//   full is low. req_type 0 appends a byte; 1 flushes the held prefix.
//   Result queue: while empty is low the oldest word (out_byte,
//   is_replacement, last_of_run) is on out_res; pop takes it. last_of_run
//   marks the final byte caused by one input word.
//   Scanning: the scanner takes an input word in a load step, then emits
//   its result bytes one per cycle while the receiver keeps up; a word
//   that yields nothing still needs a scan step after the load. A
//   replaced lead byte yields the three bytes of U+FFFD, so a word yields
//   from no byte up to twelve bytes; the single output byte register sets
//   the one-byte-per-cycle ceiling. After an input word is taken, its first
//   byte reaches out_res through the scanner buffer and output register.
//   The input queue holds QUEUE_DEPTH words so the sender keeps pushing
//   while the scanner works or the receiver stalls; a stalled receiver
//   freezes the scanner with the current byte held on out_res.
//   Reset (synchronous, active low) empties both queues and drops any held
//   prefix bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_sanitizer import u8s_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  u8s_in_t  in_req,
  output logic     empty,
  input  logic     pop,
  output u8s_out_t out_res
);

  logic     q_valid;
  logic     q_take;
  u8s_req_t q_req;
  logic     out_repl;
  logic     repl_byte_ok;
  logic     repl_last;

  // Accept and classify input words
  u8s_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_req  (in_req),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_take  (q_take)
  );

  // Scan and emit sanitized bytes
  u8s_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_take  (q_take),
    .pop     (pop),
    .empty   (empty),
    .out_res (out_res)
  );

  // Qualifiers for the checks below
  assign out_repl     = !empty && out_res.is_replacement;
  assign repl_byte_ok = (out_res.out_byte == REPL_B0) || (out_res.out_byte == REPL_B1) ||
                        (out_res.out_byte == REPL_B2);
  assign repl_last    = out_repl && out_res.last_of_run;

  // Replacement words only carry the three bytes of U+FFFD
  `ASSERT_IMPL(a_repl_byte, clk, rst_n, out_repl, repl_byte_ok)

  // A run never ends in the middle of a replacement
  `ASSERT_IMPL(a_repl_last, clk, rst_n, repl_last, out_res.out_byte == REPL_B2)

  // The scanner never reads an empty queue
  `ASSERT_IMPL(a_take_valid, clk, rst_n, q_take, q_valid)

  // After taking a word the scanner scans it before it takes another
  `ASSERT_NEXT(a_take_gap, clk, rst_n, q_take, !q_take)

endmodule
